// File: sv/sdau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdau_pkg
// Shared types and constants for the stick direction autorepeat unit.
// ----------------------------------------------------------------------------
package sdau_pkg;

  localparam int LANES     = 4;
  localparam int STICK_W   = 8;
  localparam int THR_W     = 7;
  localparam int CNT_W     = 16;
  localparam int DIR_W     = 3;
  localparam int STEP_W    = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 24;

  localparam logic [DIR_W-1:0] DIR_NEUTRAL = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UP      = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FIRE_FRAMES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START_FRAMES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD       = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              step;
    logic [STEP_W-1:0] bit_idx;
  } lane_ctrl_t;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             fire;
  } lane_stat_t;

endpackage

// File: sv/sdau_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdau_lane
// One player: direction classify, hold counter, bit-serial remainder of the
// hold count by the repeat period, and the fire decision.
// ----------------------------------------------------------------------------
module sdau_lane
  import sdau_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  lane_ctrl_t                ctrl,
  input  logic signed [STICK_W-1:0] stick_x,
  input  logic signed [STICK_W-1:0] stick_y,
  input  logic [THR_W-1:0]          stick_threshold,
  input  logic [CNT_W-1:0]          first_fire_frames,
  input  logic [CNT_W-1:0]          repeat_start_frames,
  input  logic [CNT_W-1:0]          repeat_period,
  input  logic [DIR_W-1:0]          query,
  output lane_stat_t                stat
);

  logic [CNT_W-1:0]  hold_count;
  logic [DIR_W-1:0]  held_direction;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rem_next;
  logic [CNT_W:0]    rem_shift;
  logic [DIR_W-1:0]  dir_new;
  logic signed [STICK_W:0] thr_pos;
  logic signed [STICK_W:0] thr_neg;
  logic signed [STICK_W:0] x_ext;
  logic signed [STICK_W:0] y_ext;

  assign thr_pos = $signed({2'b00, stick_threshold});
  assign thr_neg = -thr_pos;
  assign x_ext   = {stick_x[STICK_W-1], stick_x};
  assign y_ext   = {stick_y[STICK_W-1], stick_y};

  always_comb begin
    if (x_ext > thr_pos) begin
      dir_new = DIR_RIGHT;
    end else if (x_ext < thr_neg) begin
      dir_new = DIR_LEFT;
    end else if (y_ext > thr_pos) begin
      dir_new = DIR_UP;
    end else if (y_ext < thr_neg) begin
      dir_new = DIR_DOWN;
    end else begin
      dir_new = DIR_NEUTRAL;
    end
  end

  // restoring remainder, MSB first
  always_comb begin
    rem_shift = {rem, hold_count[ctrl.bit_idx]};
    if (rem_shift >= {1'b0, repeat_period}) begin
      rem_next = CNT_W'(rem_shift - {1'b0, repeat_period});
    end else begin
      rem_next = rem_shift[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count     <= '0;
      held_direction <= DIR_NEUTRAL;
    end else if (ctrl.start) begin
      held_direction <= dir_new;
      if (dir_new == DIR_NEUTRAL) begin
        hold_count <= '0;
      end else begin
        hold_count <= hold_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
    end else if (ctrl.step) begin
      rem <= rem_next;
    end
  end

  assign stat.dir  = held_direction;
  assign stat.fire = (held_direction == query) &&
                     ((hold_count == first_fire_frames) ||
                      ((hold_count > first_fire_frames) &&
                       (hold_count >= repeat_start_frames) &&
                       (repeat_period != '0) && (rem == '0)));

endmodule

// File: sv/sdau_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdau_merge
// Combines the lane results into the pulse mask, any/all flags and the
// packed result word.
// ----------------------------------------------------------------------------
module sdau_merge
  import sdau_pkg::*;
#(
  parameter int PLAYERS = 4
) (
  input  lane_stat_t       stat [LANES],
  output logic [OUT_W-1:0] data
);

  localparam logic [LANES-1:0] PRESENT = LANES'((1 << PLAYERS) - 1);

  logic [LANES-1:0] mask;
  logic             any_pulse;
  logic             all_pulse;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mask[i] = stat[i].fire;
    end
  end

  assign any_pulse = |mask;
  assign all_pulse = (mask == PRESENT);

  assign data = {6'b0, all_pulse, any_pulse, mask,
                 stat[3].dir, stat[2].dir, stat[1].dir, stat[0].dir};

endmodule

// File: sv/stick_direction_autorepeat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_direction_autorepeat_unit
// Four-player stick direction classifier with typematic autorepeat pulses.
// ----------------------------------------------------------------------------
// One request per video frame arrives on s_*: four players' signed stick
// samples plus a queried direction. Each player has its own lane; a merge
// stage builds the per-player directions, the pulse mask for the query and
// the any/all flags, and the result leaves on m_* from an output register.
// The lanes compute the bit-serial remainder of the 16-bit hold count by
// the repeat period in the CALC state; the merged result is then loaded
// into the output register from the DONE state. s_tready is high only
// while the lanes are idle. A new request may be taken while the previous
// result still waits on m_*; if the receiver keeps stalling, the finished
// result is held in the lanes and s_tready stays low until the output
// drains. Configuration (cfg_*) must be written only while idle, which the
// block itself does not enforce; it takes effect on the next request.
// Reset clears all hold counters to zero, directions to neutral, and
// loads threshold 40, first fire 1, repeat start 28, period 4.
// ----------------------------------------------------------------------------
module stick_direction_autorepeat_unit
  import sdau_pkg::*;
#(
  parameter int PLAYERS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // p1_stick_x, p1_stick_y, p2_stick_x, p2_stick_y, p3_stick_x, p3_stick_y,
  // p4_stick_x, p4_stick_y, query_direction, zero fill
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // p1_direction, p2_direction, p3_direction, p4_direction, pulse_mask,
  // any_pulse, all_pulse, zero fill
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [LANES-1:0]  PRESENT   = LANES'((1 << PLAYERS) - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = '1;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [THR_W-1:0]  stick_threshold;
  logic [CNT_W-1:0]  first_fire_frames;
  logic [CNT_W-1:0]  repeat_start_frames;
  logic [CNT_W-1:0]  repeat_period;
  logic [DIR_W-1:0]  query;
  logic              accept;
  logic              out_load;
  lane_ctrl_t        ctrl;
  lane_stat_t        stat [LANES];
  logic [OUT_W-1:0]  merged;
  logic [OUT_W-1:0]  out_data;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_threshold     <= THR_W'(40);
      first_fire_frames   <= CNT_W'(1);
      repeat_start_frames <= CNT_W'(28);
      repeat_period       <= CNT_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STICK_THRESHOLD:     stick_threshold     <= cfg_data[THR_W-1:0];
        REG_FIRST_FIRE_FRAMES:   first_fire_frames   <= cfg_data;
        REG_REPEAT_START_FRAMES: repeat_start_frames <= cfg_data;
        REG_REPEAT_PERIOD:       repeat_period       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: if (step_cnt == '0) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE);
    ctrl.start   = (state == ST_IDLE) && s_tvalid;
    ctrl.step    = (state == ST_CALC);
    ctrl.bit_idx = step_cnt;
    out_load     = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= LAST_STEP;
    end else begin
      state <= state_next;
      if (accept) begin
        step_cnt <= LAST_STEP;
      end else if (state == ST_CALC) begin
        step_cnt <= step_cnt - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query <= s_tdata[8*STICK_W +: DIR_W];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < PLAYERS) begin : g_on
      sdau_lane u_lane (
        .clk                 (clk),
        .rst                 (rst),
        .ctrl                (ctrl),
        .stick_x             (s_tdata[2*i*STICK_W +: STICK_W]),
        .stick_y             (s_tdata[(2*i+1)*STICK_W +: STICK_W]),
        .stick_threshold     (stick_threshold),
        .first_fire_frames   (first_fire_frames),
        .repeat_start_frames (repeat_start_frames),
        .repeat_period       (repeat_period),
        .query               (query),
        .stat                (stat[i])
      );
    end else begin : g_off
      assign stat[i] = '0;
    end
  end

  sdau_merge #(
    .PLAYERS (PLAYERS)
  ) u_merge (
    .stat (stat),
    .data (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= merged;
    end
  end

  assign m_tdata = out_data;

  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CALC) && (step_cnt == LAST_STEP))
    else $error("request did not start the remainder sequence");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && (step_cnt == '0) |=> (state == ST_DONE))
    else $error("remainder sequence did not finish after its last step");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_data[17] |-> out_data[16])
    else $error("all_pulse without any_pulse");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_data[15:12] & ~PRESENT) == '0))
    else $error("pulse from an absent player");

  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_DONE) && !(m_tvalid && !m_tready))
    else $error("result overwrote an unread output");

endmodule
